/* sv/smx_pkg.sv */
package smx_pkg;

    localparam int MAX_COLS_DEF    = 64;
    localparam int SCORE_WIDTH_DEF = 16;

    // widest row count (4096) and widest score carried in a row descriptor
    localparam int CNT_MAX_W   = 13;
    localparam int SCORE_MAX_W = 32;

    localparam int EXP_W     = 17;   // exp value, Q1.16, at most 65536
    localparam int SUM_W     = 24;   // saturating sum of exp values
    localparam int V_W       = 31;   // Q1.30 running product
    localparam int INV_W     = 17;   // reciprocal; sum >= 1.0 keeps it <= 65536
    localparam int EXP_STEPS = 16;
    localparam int DIV_STEPS = 33;
    localparam int LOG2E_W   = 17;

    localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;

    typedef struct packed {
        logic                   bank;
        logic                   drop;
        logic [CNT_MAX_W-1:0]   count;
        logic [SCORE_MAX_W-1:0] row_max;
    } desc_t;

    typedef logic [EXP_STEPS:1][V_W-1:0] root_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x   = x_in;
        res = 64'd0;
        b   = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= res + b)
            begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // root k approximates 2^(-2^-k) in Q1.30
    function automatic root_tab_t build_roots();
        root_tab_t r;
        logic [63:0] t;
        t    = isqrt64(64'd1 << 59);
        r[1] = t[V_W-1:0];
        for (int k = 2; k <= EXP_STEPS; k++)
        begin
            t    = isqrt64(64'(r[k-1]) << 30);
            r[k] = t[V_W-1:0];
        end
        return r;
    endfunction

    localparam root_tab_t ROOTS = build_roots();

endpackage

/* sv/smx_ram.sv */
module smx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/smx_desc_q.sv */
module smx_desc_q (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  smx_pkg::desc_t push_desc,
    input  logic           pop,
    output logic           head_valid,
    output smx_pkg::desc_t head
);

    import smx_pkg::*;

    desc_t      entry_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] fill_reg, fill_next;

    assign head_valid = fill_reg != 2'd0;
    assign head       = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop  ? ~rptr_reg : rptr_reg;
        fill_next = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_desc;
        end
    end

endmodule

/* sv/smx_front.sv */
module smx_front #(
    parameter int MAX_COLS    = smx_pkg::MAX_COLS_DEF,
    parameter int SCORE_WIDTH = smx_pkg::SCORE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SCORE_WIDTH-1:0] score,
    input  logic                          row_end,
    output logic                          wr_en,
    output logic [$clog2(MAX_COLS):0]     wr_addr,
    output logic [SCORE_WIDTH-1:0]        wr_data,
    output logic                          desc_push,
    output smx_pkg::desc_t                desc,
    input  logic                          row_done
);

    import smx_pkg::*;

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int CNT_W  = $clog2(MAX_COLS + 1);

    logic [CNT_W-1:0]              count_reg, count_next;
    logic signed [SCORE_WIDTH-1:0] max_reg, max_next;
    logic                          drop_reg, drop_next;
    logic                          bank_reg, bank_next;
    logic [1:0]                    busy_reg, busy_next;

    logic                          accept;
    logic                          keep;
    logic signed [SCORE_WIDTH-1:0] max_upd;
    logic [CNT_W-1:0]              count_upd;
    logic                          drop_upd;

    // two rows in flight: one being written, one with the back end
    assign in_stall = busy_reg == 2'd2;
    assign accept   = in_valid && !in_stall;
    assign keep     = count_reg < CNT_W'(MAX_COLS);

    assign max_upd   = (keep && score > max_reg) ? score : max_reg;
    assign count_upd = count_reg + CNT_W'(keep);
    assign drop_upd  = drop_reg | ~keep;

    assign wr_en   = accept && keep;
    assign wr_addr = {bank_reg, count_reg[ADDR_W-1:0]};
    assign wr_data = score;

    assign desc_push     = accept && row_end;
    assign desc.bank     = bank_reg;
    assign desc.drop     = drop_upd;
    assign desc.count    = CNT_MAX_W'(count_upd);
    assign desc.row_max  = SCORE_MAX_W'(max_upd);

    always_comb
    begin
        count_next = count_reg;
        max_next   = max_reg;
        drop_next  = drop_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (row_end)
            begin
                count_next = '0;
                max_next   = {1'b1, {(SCORE_WIDTH-1){1'b0}}};
                drop_next  = 1'b0;
                bank_next  = ~bank_reg;
            end
            else
            begin
                count_next = count_upd;
                max_next   = max_upd;
                drop_next  = drop_upd;
            end
        end
        busy_next = busy_reg + 2'(desc_push) - 2'(row_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= {1'b1, {(SCORE_WIDTH-1){1'b0}}};
            drop_reg  <= 1'b0;
            bank_reg  <= 1'b0;
            busy_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            max_reg   <= max_next;
            drop_reg  <= drop_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

/* sv/smx_back.sv */
module smx_back #(
    parameter int MAX_COLS    = smx_pkg::MAX_COLS_DEF,
    parameter int SCORE_WIDTH = smx_pkg::SCORE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  smx_pkg::desc_t                q_head,
    output logic                          q_pop,
    output logic [$clog2(MAX_COLS):0]     rd_addr,
    input  logic [SCORE_WIDTH-1:0]        rd_data,
    output logic                          row_done,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [15:0]                   prob,
    output logic                          row_last,
    output logic                          overflowed
);

    import smx_pkg::*;

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int P_W    = SCORE_WIDTH + 9;
    localparam int IP_W   = SCORE_WIDTH - 7;
    localparam int PRD_W  = EXP_W + INV_W;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_LOAD = 10'b00_0000_0010,
        S_DIFF = 10'b00_0000_0100,
        S_MUL  = 10'b00_0000_1000,
        S_ITER = 10'b00_0001_0000,
        S_FIN  = 10'b00_0010_0000,
        S_DIV  = 10'b00_0100_0000,
        S_PRD  = 10'b00_1000_0000,
        S_PMUL = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } state_t;

    state_t                        state_reg, state_next;
    logic [ADDR_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          bank_reg, bank_next;
    logic                          drop_reg, drop_next;
    logic signed [SCORE_WIDTH-1:0] max_reg, max_next;
    logic [SCORE_WIDTH-1:0]        m_reg, m_next;
    logic [P_W-1:0]                p_reg, p_next;
    logic [V_W-1:0]                v_reg, v_next;
    logic [3:0]                    step_reg, step_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [SUM_W:0]                rem_reg, rem_next;
    logic [INV_W-1:0]              inv_reg, inv_next;
    logic [5:0]                    dcnt_reg, dcnt_next;
    logic [PRD_W-1:0]              prd_reg, prd_next;
    logic                          out_valid_reg, out_valid_next;
    logic [15:0]                   prob_reg, prob_next;
    logic                          last_reg, last_next;
    logic                          ovf_reg, ovf_next;

    logic signed [SCORE_WIDTH:0]   diff;
    logic [SCORE_WIDTH+LOG2E_W-1:0] p_full;
    logic [V_W-1:0]                root;
    logic [2*V_W-1:0]              v_prod;
    logic [IP_W-1:0]               ip;
    logic [4:0]                    sh;
    logic [31:0]                   e_full;
    logic [EXP_W-1:0]              e_val;
    logic [SUM_W:0]                sum_ext;
    logic [SUM_W:0]                rem_sh;
    logic                          qbit;
    logic [PRD_W:0]                rounded;
    logic                          is_last;
    logic                          out_free;
    logic                          exp_wr;
    logic [EXP_W-1:0]              exp_rd;

    smx_ram #(
        .WIDTH (EXP_W),
        .DEPTH (2**ADDR_W)
    ) u_exp_ram (
        .clk     (clk),
        .wr_en   (exp_wr),
        .wr_addr (idx_reg),
        .wr_data (e_val),
        .rd_addr (idx_reg),
        .rd_data (exp_rd)
    );

    assign rd_addr    = {bank_reg, idx_reg};
    assign out_valid  = out_valid_reg;
    assign prob       = prob_reg;
    assign row_last   = last_reg;
    assign overflowed = ovf_reg;

    assign is_last  = CNT_W'(idx_reg) + CNT_W'(1) == count_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // exp datapath
    assign diff   = (SCORE_WIDTH+1)'(max_reg) - (SCORE_WIDTH+1)'(signed'(rd_data));
    assign p_full = (SCORE_WIDTH+LOG2E_W)'(m_reg) * (SCORE_WIDTH+LOG2E_W)'(LOG2E_Q16);
    assign root   = p_reg[15 - step_reg] ? ROOTS[5'(step_reg) + 5'd1] : V_W'(1 << 30);
    assign v_prod = (2*V_W)'(v_reg) * (2*V_W)'(root) + (2*V_W)'(1 << 29);
    assign ip     = p_reg[P_W-1:16];
    assign sh     = 5'(ip) + 5'd14;
    assign e_full = (32'(v_reg) + (32'd1 << (sh - 5'd1))) >> sh;
    assign e_val  = (32'(ip) > 32'd16) ? '0 : e_full[EXP_W-1:0];
    assign sum_ext = {1'b0, sum_reg} + (SUM_W+1)'(e_val);
    assign exp_wr = state_reg == S_FIN;

    // restoring division of 2^32 by the sum, one quotient bit a cycle
    assign rem_sh = {rem_reg[SUM_W-1:0], dcnt_reg == 6'd0};
    assign qbit   = rem_sh >= {1'b0, sum_reg};

    assign rounded = (PRD_W+1)'(prd_reg) + (PRD_W+1)'(1 << 15);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        bank_next      = bank_reg;
        drop_next      = drop_reg;
        max_next       = max_reg;
        m_next         = m_reg;
        p_next         = p_reg;
        v_next         = v_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        inv_next       = inv_reg;
        dcnt_next      = dcnt_reg;
        prd_next       = prd_reg;
        out_valid_next = out_valid_reg && out_stall;
        prob_next      = prob_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        q_pop          = 1'b0;
        row_done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    count_next = CNT_W'(q_head.count);
                    bank_next  = q_head.bank;
                    drop_next  = q_head.drop;
                    max_next   = SCORE_WIDTH'(q_head.row_max);
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                m_next     = diff[SCORE_WIDTH-1:0];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                p_next     = p_full[SCORE_WIDTH+LOG2E_W-1:8];
                v_next     = V_W'(1 << 30);
                step_next  = '0;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                v_next    = v_prod[V_W+29:30];
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                sum_next = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                if (is_last)
                begin
                    idx_next   = '0;
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_LOAD;
                end
            end
            S_DIV:
            begin
                rem_next  = qbit ? rem_sh - {1'b0, sum_reg} : rem_sh;
                inv_next  = {inv_reg[INV_W-2:0], qbit};
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'(DIV_STEPS - 1))
                begin
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                prd_next   = PRD_W'(exp_rd) * PRD_W'(inv_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    prob_next      = (rounded[PRD_W:16] > (PRD_W-15)'(16'hFFFF)) ?
                                     16'hFFFF : rounded[31:16];
                    last_next      = is_last;
                    ovf_next       = drop_reg;
                    if (is_last)
                    begin
                        row_done   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_PRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        count_reg <= count_next;
        bank_reg  <= bank_next;
        drop_reg  <= drop_next;
        max_reg   <= max_next;
        m_reg     <= m_next;
        p_reg     <= p_next;
        v_reg     <= v_next;
        step_reg  <= step_next;
        sum_reg   <= sum_next;
        rem_reg   <= rem_next;
        inv_reg   <= inv_next;
        dcnt_reg  <= dcnt_next;
        prd_reg   <= prd_next;
        prob_reg  <= prob_next;
        last_reg  <= last_next;
        ovf_reg   <= ovf_next;
    end

endmodule

/* sv/softmax_row_normalizer.sv */
// channel | words                           | handshake
// in      | score (Q8.8), row_end           | in_valid / in_stall
// out     | prob (Q0.16), row_last, overflowed | out_valid / out_stall
//
// Input words take one cycle each while a row bank is free; two row banks
// let the next row load while the back end works on the previous one.
// The back end works a row of kept words in three passes: exp per word
// (one 31x31 multiply per root step), the reciprocal (one quotient bit
// a cycle), then scaling per word.
// in_stall rises once a second row ends while the first is still in work.
// Reset is asynchronous and active low; no clearing pass is needed.
module softmax_row_normalizer #(
    parameter int MAX_COLS    = smx_pkg::MAX_COLS_DEF,
    parameter int SCORE_WIDTH = smx_pkg::SCORE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SCORE_WIDTH-1:0] score,
    input  logic                          row_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [15:0]                   prob,
    output logic                          row_last,
    output logic                          overflowed
);

    import smx_pkg::*;

    localparam int ADDR_W = $clog2(MAX_COLS);

    logic                   wr_en;
    logic [ADDR_W:0]        wr_addr;
    logic [SCORE_WIDTH-1:0] wr_data;
    logic [ADDR_W:0]        rd_addr;
    logic [SCORE_WIDTH-1:0] rd_data;
    logic                   desc_push;
    desc_t                  desc;
    logic                   q_valid;
    desc_t                  q_head;
    logic                   q_pop;
    logic                   row_done;

    // front: store scores, track max, hand a row descriptor over on row end
    smx_front #(
        .MAX_COLS    (MAX_COLS),
        .SCORE_WIDTH (SCORE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .score     (score),
        .row_end   (row_end),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .desc_push (desc_push),
        .desc      (desc),
        .row_done  (row_done)
    );

    // two banks of row storage, bank picked by the top address bit
    smx_ram #(
        .WIDTH (SCORE_WIDTH),
        .DEPTH (2**(ADDR_W+1))
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    smx_desc_q u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (desc_push),
        .push_desc  (desc),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    // back: exp pass, reciprocal, scaling pass
    smx_back #(
        .MAX_COLS    (MAX_COLS),
        .SCORE_WIDTH (SCORE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .row_done   (row_done),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .prob       (prob),
        .row_last   (row_last),
        .overflowed (overflowed)
    );

endmodule

/* sv/smx_checker.sv */
module smx_checker #(
    parameter int MAX_COLS = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] prob,
    input logic        row_last,
    input logic        overflowed
);

    localparam int CNT_W = $clog2(MAX_COLS + 1);

    logic             out_acc;
    logic [CNT_W-1:0] cnt_reg;
    logic             in_row_reg;
    logic             ovf_reg;
    logic             seen_reg;

    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            in_row_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            seen_reg   <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                seen_reg <= 1'b1;
            end
            if (out_acc)
            begin
                cnt_reg    <= row_last ? '0 : cnt_reg + CNT_W'(1);
                in_row_reg <= !row_last;
                ovf_reg    <= overflowed;
            end
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(prob) && $stable(row_last)
            && $stable(overflowed))
        else $error("stalled output word changed");

    a_ovf_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_row_reg |-> overflowed == ovf_reg)
        else $error("overflowed flag changed within a row");

    a_row_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg < CNT_W'(MAX_COLS))
        else $error("row longer than MAX_COLS words");

    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_reg)
        else $error("output word before any input word");

endmodule

bind softmax_row_normalizer smx_checker #(
    .MAX_COLS (MAX_COLS)
) u_smx_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .prob       (prob),
    .row_last   (row_last),
    .overflowed (overflowed)
);
